// ===== rtl/pvm_pkg.sv =====
package pvm_pkg;

    localparam int DEF_VOICES        = 8;
    localparam int DEF_BLOCK_SAMPLES = 4096;
    localparam int DEF_SAMPLE_DEPTH  = 16384;

    localparam logic signed [15:0] PCM_MIN = 16'sh8000;
    localparam logic signed [15:0] PCM_MAX = 16'sh7fff;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [13:0] base;
        logic [14:0] len;
        logic [14:0] cursor;
        logic        loop;
    } voice_t;

    typedef struct packed {
        logic [13:0] base;
        logic [14:0] len;
        logic        loop;
    } pending_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_RD,
        ST_R_CHK,
        ST_R_MOVE,
        ST_A_RD,
        ST_A_WR,
        ST_M_RD,
        ST_M_CHK,
        ST_MOD,
        ST_MOD_SUB,
        ST_MOD_FIX,
        ST_M_ADD,
        ST_EMIT
    } state_t;

    function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (s < 17'(PCM_MIN))
            return PCM_MIN;
        else if (s > 17'(PCM_MAX))
            return PCM_MAX;
        else
            return s[15:0];
    endfunction

endpackage

// ===== rtl/pvm_if.sv =====
interface pvm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [13:0]        address;
    logic signed [15:0] sample_value;
    logic [14:0]        voice_length;
    logic               loop_flag;

    modport source (output valid, command, address, sample_value, voice_length, loop_flag,
                    input ready);
    modport sink   (input valid, command, address, sample_value, voice_length, loop_flag,
                    output ready);
endinterface

interface pvm_rsp_if #(parameter int COUNT_W = 4);
    logic               valid;
    logic               ready;
    logic signed [15:0] mixed_sample;
    logic [COUNT_W-1:0] active_voices;

    modport source (output valid, mixed_sample, active_voices, input ready);
    modport sink   (input valid, mixed_sample, active_voices, output ready);
endinterface

// ===== rtl/pvm_ram.sv =====
module pvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/pcm_voice_mixer.sv =====
// Load and start are handled while idle; a load whose address is not below the depth is first reduced modulo depth.
// Tick: each voice is read and, if still playing, its sample is added; base+cursor >= depth is reduced modulo depth.
// At a block boundary the slots are first scanned to retire finished voices, then pending voices are admitted.
// The result is posted once the previous result has been taken.
// Throughput: one request at a time; ready only while idle.
// Reset: rst_n async active low clears counts, block position and handshake state.
module pcm_voice_mixer #(
    parameter int VOICES        = pvm_pkg::DEF_VOICES,
    parameter int BLOCK_SAMPLES = pvm_pkg::DEF_BLOCK_SAMPLES,
    parameter int SAMPLE_DEPTH  = pvm_pkg::DEF_SAMPLE_DEPTH,
    parameter int CW            = $clog2(VOICES + 1)
) (
    input  logic     clk,
    input  logic     rst_n,
    pvm_req_if.sink  req,
    pvm_rsp_if.source rsp
);
    import pvm_pkg::*;

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int SW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int BW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam logic [27:0] DEPTH_C = 28'(SAMPLE_DEPTH);
    localparam logic [24:0] RECIP = 25'((64'd1 << 32) / 64'(SAMPLE_DEPTH));
    localparam logic [CW-1:0] VOICES_C = CW'(VOICES);
    localparam logic [BW-1:0] BLK_LAST = BW'(BLOCK_SAMPLES - 1);

    state_t state_reg, state_next;
    logic [SW-1:0] s_reg, s_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [BW-1:0] bpos_reg, bpos_next;
    logic signed [15:0] acc_reg, acc_next;
    logic [15:0] mod_reg, mod_next;
    logic [8:0]  q_reg, q_next;
    logic        mod_load_reg, mod_load_next;
    logic [15:0] val_reg, val_next;
    logic signed [15:0] out_sample_reg, out_sample_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic        out_valid_reg, out_valid_next;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [15:0]   s_wdata, s_rdata;
    logic          v_we;
    logic [SW-1:0] v_waddr, v_raddr;
    voice_t        v_wdata, v_rdata;
    logic          p_we;
    logic [SW-1:0] p_waddr, p_raddr;
    pending_t      p_wdata, p_rdata;

    logic          accept;
    logic          v_done;
    logic [14:0]   cur;
    logic [15:0]   vaddr_sum;
    logic [40:0]   prod;
    logic [27:0]   qd;
    logic [15:0]   mod_fix;

    pvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    pvm_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICES)) u_voice_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    pvm_ram #(.WIDTH($bits(pending_t)), .DEPTH(VOICES)) u_pend_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign req.ready         = (state_reg == ST_IDLE);
    assign accept            = req.valid && req.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.mixed_sample  = out_sample_reg;
    assign rsp.active_voices = out_count_reg;

    assign v_done    = (v_rdata.cursor == v_rdata.len) && !v_rdata.loop;
    assign cur       = (v_rdata.cursor == v_rdata.len) ? 15'd0 : v_rdata.cursor;
    assign vaddr_sum = {2'b0, v_rdata.base} + {1'b0, cur};

    // reciprocal estimate, quotient low by at most one
    assign prod    = {25'b0, mod_reg} * {16'b0, RECIP};
    assign qd      = 28'(q_reg) * DEPTH_C;
    assign mod_fix = (28'(mod_reg) >= DEPTH_C) ? mod_reg - DEPTH_C[15:0] : mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pcount_reg    <= '0;
            bpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pcount_reg    <= pcount_next;
            bpos_reg      <= bpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        acc_reg        <= acc_next;
        mod_reg        <= mod_next;
        q_reg          <= q_next;
        mod_load_reg   <= mod_load_next;
        val_reg        <= val_next;
        out_sample_reg <= out_sample_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        count_next      = count_reg;
        pcount_next     = pcount_reg;
        bpos_next       = bpos_reg;
        acc_next        = acc_reg;
        mod_next        = mod_reg;
        q_next          = q_reg;
        mod_load_next   = mod_load_reg;
        val_next        = val_reg;
        out_sample_next = out_sample_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg;

        s_we    = 1'b0;
        s_waddr = AW'(req.address);
        s_wdata = req.sample_value;
        s_raddr = AW'(vaddr_sum);
        v_we    = 1'b0;
        v_waddr = s_reg;
        v_wdata = v_rdata;
        v_raddr = s_reg;
        p_we    = 1'b0;
        p_waddr = SW'(pcount_reg);
        p_wdata = '{base: req.address, len: req.voice_length, loop: req.loop_flag};
        p_raddr = SW'(k_reg);

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(req.command))
                        CMD_LOAD:
                        begin
                            val_next      = req.sample_value;
                            mod_load_next = 1'b1;
                            if (28'(req.address) < DEPTH_C)
                                s_we = 1'b1;
                            else
                            begin
                                mod_next   = {2'b0, req.address};
                                state_next = ST_MOD;
                            end
                        end
                        CMD_START:
                        begin
                            if (req.voice_length != 15'd0 && pcount_reg < VOICES_C)
                            begin
                                p_we        = 1'b1;
                                pcount_next = pcount_reg + CW'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            acc_next      = '0;
                            i_next        = '0;
                            k_next        = '0;
                            mod_load_next = 1'b0;
                            if (bpos_reg != '0)
                                state_next = ST_M_RD;
                            else if (count_reg == '0)
                                state_next = ST_A_RD;
                            else
                            begin
                                s_next     = SW'(count_reg - CW'(1));
                                state_next = ST_R_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_R_RD:
            begin
                v_raddr    = s_reg;
                state_next = ST_R_CHK;
            end
            ST_R_CHK:
            begin
                if (v_done)
                begin
                    v_raddr    = SW'(count_reg - CW'(1));
                    state_next = ST_R_MOVE;
                end
                else if (s_reg == '0)
                    state_next = ST_A_RD;
                else
                begin
                    s_next     = s_reg - SW'(1);
                    state_next = ST_R_RD;
                end
            end
            ST_R_MOVE:
            begin
                v_we       = 1'b1;
                v_waddr    = s_reg;
                v_wdata    = v_rdata;
                count_next = count_reg - CW'(1);
                if (s_reg == '0)
                    state_next = ST_A_RD;
                else
                begin
                    s_next     = s_reg - SW'(1);
                    state_next = ST_R_RD;
                end
            end
            ST_A_RD:
            begin
                if (k_reg == pcount_reg || count_reg == VOICES_C)
                begin
                    pcount_next = '0;
                    state_next  = ST_M_RD;
                end
                else
                begin
                    p_raddr    = SW'(k_reg);
                    state_next = ST_A_WR;
                end
            end
            ST_A_WR:
            begin
                v_we       = 1'b1;
                v_waddr    = SW'(count_reg);
                v_wdata    = '{base: p_rdata.base, len: p_rdata.len, cursor: 15'd0,
                               loop: p_rdata.loop};
                count_next = count_reg + CW'(1);
                k_next     = k_reg + CW'(1);
                state_next = ST_A_RD;
            end
            ST_M_RD:
            begin
                if (i_reg == count_reg)
                    state_next = ST_EMIT;
                else
                begin
                    v_raddr    = SW'(i_reg);
                    state_next = ST_M_CHK;
                end
            end
            ST_M_CHK:
            begin
                if (v_done)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_M_RD;
                end
                else
                begin
                    v_we    = 1'b1;
                    v_waddr = SW'(i_reg);
                    v_wdata = '{base: v_rdata.base, len: v_rdata.len, cursor: cur + 15'd1,
                                loop: v_rdata.loop};
                    s_raddr = AW'(vaddr_sum);
                    if (28'(vaddr_sum) < DEPTH_C)
                        state_next = ST_M_ADD;
                    else
                    begin
                        mod_next   = vaddr_sum;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                q_next     = prod[40:32];
                state_next = ST_MOD_SUB;
            end
            ST_MOD_SUB:
            begin
                mod_next   = mod_reg - qd[15:0];
                state_next = ST_MOD_FIX;
            end
            ST_MOD_FIX:
            begin
                if (mod_load_reg)
                begin
                    s_we       = 1'b1;
                    s_waddr    = AW'(mod_fix);
                    s_wdata    = val_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    s_raddr    = AW'(mod_fix);
                    state_next = ST_M_ADD;
                end
            end
            ST_M_ADD:
            begin
                acc_next   = sat_add(acc_reg, s_rdata);
                i_next     = i_reg + CW'(1);
                state_next = ST_M_RD;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = acc_reg;
                    out_count_next  = count_reg;
                    bpos_next       = (bpos_reg == BLK_LAST) ? '0 : bpos_reg + BW'(1);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= VOICES_C && pcount_reg <= VOICES_C)
        else $error("voice or pending count above capacity");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req.ready)
        else $error("request taken while busy");

    a_emit_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!out_valid_reg || rsp.ready)) |=>
        (state_reg == ST_IDLE && out_valid_reg))
        else $error("emit did not post a result");

    a_admit_clears_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_RD && (k_reg == pcount_reg || count_reg == VOICES_C)) |=>
        pcount_reg == '0)
        else $error("pending queue not flushed at boundary");
endmodule

// ===== test/pvm_mix_checker.sv =====
`timescale 1ns / 100ps

module pvm_mix_checker
    import pvm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pvm_req_if     req,
    pvm_rsp_if     rsp,
    output int     errors,
    output int     outstanding
);

    localparam int NV    = DEF_VOICES;
    localparam int BLOCK = DEF_BLOCK_SAMPLES;
    localparam int DEPTH = DEF_SAMPLE_DEPTH;

    typedef struct {
        logic signed [15:0] mixed;
        logic [3:0]         count;
    } mix_out_t;

    logic [15:0] pcm_mem [DEPTH];
    voice_t      slot [NV];
    pending_t    queued [NV];
    int          slot_count;
    int          queued_count;
    int          block_pos;
    mix_out_t    mix_q [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic signed [15:0] clip_add(int acc, logic signed [15:0] w);
        int s;
        s = acc + int'(w);
        if (s < -32768)
            s = -32768;
        if (s > 32767)
            s = 32767;
        return 16'(s);
    endfunction

    task automatic retire_and_fill();
        int n;
        for (int i = slot_count; i > 0; i--)
        begin
            if (slot[i-1].cursor == slot[i-1].len && !slot[i-1].loop)
            begin
                slot[i-1] = slot[slot_count-1];
                slot_count--;
            end
        end
        n = NV - slot_count;
        if (n > queued_count)
            n = queued_count;
        for (int k = 0; k < n; k++)
        begin
            slot[slot_count].base   = queued[k].base;
            slot[slot_count].len    = queued[k].len;
            slot[slot_count].cursor = '0;
            slot[slot_count].loop   = queued[k].loop;
            slot_count++;
        end
        queued_count = 0;
    endtask

    task automatic mix_tick(output mix_out_t r);
        logic signed [15:0] acc;
        logic [13:0]        a;
        acc = '0;
        if (block_pos == 0)
            retire_and_fill();
        for (int i = 0; i < slot_count; i++)
        begin
            if (slot[i].cursor == slot[i].len)
            begin
                if (slot[i].loop)
                    slot[i].cursor = '0;
                else
                    continue;
            end
            a = 14'(32'(slot[i].base) + 32'(slot[i].cursor));
            acc = clip_add(int'(acc), pcm_mem[a]);
            slot[i].cursor++;
        end
        block_pos = (block_pos + 1) % BLOCK;
        r.mixed = acc;
        r.count = 4'(slot_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mix_out_t r;
        mix_out_t e;
        if (!rst_n)
        begin
            slot_count   = 0;
            queued_count = 0;
            block_pos    = 0;
            for (int i = 0; i < NV; i++)
                slot[i] = '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (mix_q.size() == 0)
                    report_mismatch("sample with no tick waiting");
                else
                begin
                    e = mix_q.pop_front();
                    if (rsp.mixed_sample !== e.mixed)
                        report_mismatch($sformatf("mixed_sample %0d, want %0d",
                                                  rsp.mixed_sample, e.mixed));
                    if (rsp.active_voices !== e.count)
                        report_mismatch($sformatf("active_voices %0d, want %0d",
                                                  rsp.active_voices, e.count));
                end
            end
            if (req.valid && req.ready)
            begin
                case (cmd_t'(req.command))
                    CMD_LOAD:
                        pcm_mem[req.address] = req.sample_value;
                    CMD_START:
                        if (req.voice_length != 0 && queued_count < NV)
                        begin
                            queued[queued_count] = '{req.address, req.voice_length,
                                                     req.loop_flag};
                            queued_count++;
                        end
                    CMD_TICK:
                    begin
                        mix_tick(r);
                        mix_q.push_back(r);
                    end
                    default: ;
                endcase
            end
            outstanding = mix_q.size();
        end
    end

endmodule

// ===== test/pcm_voice_mixer_test.sv =====
`timescale 1ns / 100ps

module pcm_voice_mixer_test;
    import pvm_pkg::*;

    // random voices play only from this loaded window, which wraps past the top address
    localparam logic [13:0] REGION_BASE  = 14'h3f00;
    localparam int          REGION_WORDS = 512;

    logic clk;
    logic rst_n;
    logic quiet;
    int   errors;
    int   outstanding;

    pvm_req_if req ();
    pvm_rsp_if #(.COUNT_W(4)) rsp ();

    pcm_voice_mixer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    pvm_mix_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
        rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 29);

    task automatic send_request(input cmd_t cmd, input logic [13:0] addr,
                                input logic [15:0] val, input logic [14:0] len,
                                input logic lp);
        while (!quiet && $urandom_range(99) < 29)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.address      <= addr;
        req.sample_value <= val;
        req.voice_length <= len;
        req.loop_flag    <= lp;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic random_request();
        int r;
        int o;
        logic [15:0] v;
        r = $urandom_range(99);
        v = 16'($urandom);
        o = $urandom_range(255);
        if (r < 15)
            send_request(CMD_LOAD, 14'($urandom), v, 15'($urandom), 1'($urandom));
        else if (r < 35)
            send_request(CMD_START, REGION_BASE + 14'(o), v,
                         ($urandom_range(19) == 0) ? 15'd0 :
                         15'($urandom_range(REGION_WORDS - o, 1)),
                         $urandom_range(3) == 0);
        else if (r < 95)
            send_request(CMD_TICK, 14'($urandom), v, 15'($urandom), 1'($urandom));
        else
            send_request(CMD_NONE, 14'($urandom), v, 15'($urandom), 1'($urandom));
    endtask

    initial
    begin
        logic [15:0] w;
        rst_n            = 1'b0;
        quiet            = 1'b0;
        req.valid        = 1'b0;
        req.command      = CMD_NONE;
        req.address      = '0;
        req.sample_value = '0;
        req.voice_length = '0;
        req.loop_flag    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int a = 0; a < REGION_WORDS; a++)
        begin
            case ($urandom_range(3))
                0: w = 16'h8000;
                1: w = 16'h7fff;
                default: w = 16'($urandom);
            endcase
            send_request(CMD_LOAD, REGION_BASE + 14'(a), w, '0, 1'b0);
        end

        send_request(CMD_LOAD, 14'd0, 16'h8000, 15'h7fff, 1'b1);
        send_request(CMD_LOAD, 14'h3fff, 16'h7fff, 15'd0, 1'b0);
        send_request(CMD_NONE, 14'h3fff, 16'hffff, 15'h7fff, 1'b1);
        send_request(CMD_START, 14'h3f64, '0, 15'd0, 1'b1);
        send_request(CMD_START, 14'h3fff, '0, 15'd257, 1'b1);
        send_request(CMD_START, 14'h3f00, '0, 15'd1, 1'b0);
        send_request(CMD_START, 14'h3ff0, '0, 15'd200, 1'b0);
        send_request(CMD_START, 14'h3ffe, '0, 15'd5, 1'b1);
        send_request(CMD_START, 14'h3f10, '0, 15'd3, 1'b0);
        send_request(CMD_START, 14'h3f20, '0, 15'd7, 1'b1);
        send_request(CMD_START, 14'h3f30, '0, 15'd2, 1'b0);
        send_request(CMD_START, 14'h3f40, '0, 15'd4, 1'b0);
        send_request(CMD_START, 14'h3f50, '0, 15'd9, 1'b1);
        send_request(CMD_TICK, '0, '0, '0, 1'b0);
        send_request(CMD_START, 14'h3fff, '0, 15'h7fff, 1'b1);
        send_request(CMD_START, 14'h3ff0, '0, 15'd16384, 1'b0);
        send_request(CMD_TICK, '0, '0, '0, 1'b0);
        send_request(CMD_TICK, '0, '0, '0, 1'b0);

        for (int round = 0; round < 4; round++)
        begin
            quiet = (round == 2);
            for (int i = 0; i < 320; i++)
                random_request();
        end
        quiet = 1'b0;
        repeat (3)
            send_request(CMD_TICK, '0, '0, '0, 1'b0);
        req.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== pcm_voice_mixer.f =====
rtl/pvm_pkg.sv
rtl/pvm_if.sv
rtl/pvm_ram.sv
rtl/pcm_voice_mixer.sv
test/pvm_mix_checker.sv
test/pcm_voice_mixer_test.sv
